FILE: rtl/hsfd_pkg.sv
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared types, constants and helper functions of the sensor frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

  // crc-8 of each two-byte word
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // conversion constants, hundredths of a unit
  localparam logic [14:0]        TEMP_SCALE  = 15'd17500;
  localparam logic [13:0]        HUM_SCALE   = 14'd12500;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic signed [15:0] HUM_OFFSET  = 16'sd600;
  localparam logic [13:0]        HUM_MAX     = 14'd10000;
  localparam logic [15:0]        FULL_SCALE  = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;

  localparam int TEMP_PROD_W = 31;
  localparam int HUM_PROD_W  = 30;

  // position of the next byte in the six-byte frame
  typedef enum logic [2:0] {
    POS_TEMP_MSB,
    POS_TEMP_LSB,
    POS_TEMP_CRC,
    POS_HUM_MSB,
    POS_HUM_LSB,
    POS_HUM_CRC
  } byte_pos_t;

  // one complete frame handed from front to back
  typedef struct packed {
    logic [15:0] temp_raw;
    logic [15:0] humid_raw;
    logic        crc_error;
  } frame_t;

  // msb-first crc-8 update over one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 65535 * 2^15
  // x = q0 * 65535 + (q0 + lo), and q0 + lo stays below twice the divisor
  function automatic logic [14:0] div_full_scale(input logic [TEMP_PROD_W-1:0] x);
    logic [14:0] q0;
    logic [16:0] r;
    q0 = x[TEMP_PROD_W-1:16];
    r  = {1'b0, x[15:0]} + {2'b00, q0};
    if (r >= {1'b0, FULL_SCALE}) begin
      return q0 + 15'd1;
    end
    return q0;
  endfunction

endpackage

FILE: rtl/hsfd_if.sv
// ----------------------------------------------------------------------------
// hsfd_rx_if / hsfd_res_if
// Valid/ready channels of the frame decoder: received bytes and results.
// ----------------------------------------------------------------------------
interface hsfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfd_res_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;
  logic               crc_error;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output crc_error, input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input crc_error, output ready);
endinterface

FILE: rtl/hsfd_front.sv
// ----------------------------------------------------------------------------
// hsfd_front
// Tracks the frame position, runs the crc per word and collects the raw
// words; pushes one frame record on the last byte of each frame.
// ----------------------------------------------------------------------------
module hsfd_front (
  input  logic                clk,
  input  logic                rst,
  hsfd_rx_if.sink             rx,
  input  logic                push_ready,
  output logic                push_valid,
  output hsfd_pkg::frame_t    push_data
);

  hsfd_pkg::byte_pos_t pos, pos_next, eff_pos;
  logic [7:0]  crc, crc_next, crc_cur;
  logic [15:0] temp_word, temp_word_next;
  logic [15:0] humid_word, humid_word_next;
  logic        temp_fail, temp_fail_next;
  logic        restart;
  logic        accept;

  assign rx.ready = push_ready;
  assign accept   = rx.valid && rx.ready;

  // start flag or a stray position restarts the frame
  assign restart = rx.frame_start || (pos > hsfd_pkg::POS_HUM_CRC);
  assign eff_pos = restart ? hsfd_pkg::POS_TEMP_MSB : pos;
  assign crc_cur = restart ? hsfd_pkg::CRC_INIT : crc;

  // next position
  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (eff_pos == hsfd_pkg::POS_HUM_CRC) begin
        pos_next = hsfd_pkg::POS_TEMP_MSB;
      end else begin
        pos_next = hsfd_pkg::byte_pos_t'(3'(eff_pos) + 3'd1);
      end
    end
  end

  // word assembly, crc and frame record
  always_comb begin
    crc_next        = crc;
    temp_word_next  = temp_word;
    humid_word_next = humid_word;
    temp_fail_next  = temp_fail;
    push_valid      = 1'b0;
    push_data.temp_raw  = temp_word;
    push_data.humid_raw = humid_word;
    push_data.crc_error = temp_fail || (crc_cur != rx.rx_byte);
    if (accept) begin
      unique case (eff_pos)
        hsfd_pkg::POS_TEMP_MSB: begin
          temp_word_next = {rx.rx_byte, temp_word[7:0]};
          crc_next       = hsfd_pkg::crc8_update(crc_cur, rx.rx_byte);
        end
        hsfd_pkg::POS_TEMP_LSB: begin
          temp_word_next = {temp_word[15:8], rx.rx_byte};
          crc_next       = hsfd_pkg::crc8_update(crc_cur, rx.rx_byte);
        end
        hsfd_pkg::POS_TEMP_CRC: begin
          temp_fail_next = (crc_cur != rx.rx_byte);
          crc_next       = hsfd_pkg::CRC_INIT;
        end
        hsfd_pkg::POS_HUM_MSB: begin
          humid_word_next = {rx.rx_byte, humid_word[7:0]};
          crc_next        = hsfd_pkg::crc8_update(crc_cur, rx.rx_byte);
        end
        hsfd_pkg::POS_HUM_LSB: begin
          humid_word_next = {humid_word[15:8], rx.rx_byte};
          crc_next        = hsfd_pkg::crc8_update(crc_cur, rx.rx_byte);
        end
        default: begin
          crc_next   = hsfd_pkg::CRC_INIT;
          push_valid = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= hsfd_pkg::POS_TEMP_MSB;
      crc        <= hsfd_pkg::CRC_INIT;
      temp_word  <= '0;
      humid_word <= '0;
      temp_fail  <= 1'b0;
    end else begin
      pos        <= pos_next;
      crc        <= crc_next;
      temp_word  <= temp_word_next;
      humid_word <= humid_word_next;
      temp_fail  <= temp_fail_next;
    end
  end

  // position never leaves the frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= hsfd_pkg::POS_HUM_CRC)
    else $error("frame position out of range");

  // a record is pushed only on the last byte of an accepted frame
  a_push_on_last: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (accept && eff_pos == hsfd_pkg::POS_HUM_CRC))
    else $error("frame record pushed off the last word");

endmodule

FILE: rtl/hsfd_queue.sv
// ----------------------------------------------------------------------------
// hsfd_queue
// Short frame-record queue between the front and the conversion back end.
// ----------------------------------------------------------------------------
module hsfd_queue #(
  parameter int DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  hsfd_pkg::frame_t push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output hsfd_pkg::frame_t pop_data,
  input  logic             pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hsfd_pkg::frame_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count past depth");

  // the front only offers a record when it has taken the byte
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("record pushed into a full queue");

endmodule

FILE: rtl/hsfd_back.sv
// ----------------------------------------------------------------------------
// hsfd_back
// Converts raw words to hundredths: constant multiply, then divide by
// full scale, offset, clamp humidity and zero on crc error into the result register.
// ----------------------------------------------------------------------------
module hsfd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  input  hsfd_pkg::frame_t pop_data,
  output logic             pop,
  hsfd_res_if.source       result
);

  logic                                s1_valid;
  logic [hsfd_pkg::TEMP_PROD_W-1:0]    s1_temp_prod;
  logic [hsfd_pkg::HUM_PROD_W-1:0]     s1_hum_prod;
  logic                                s1_err;
  logic                                out_free, s1_free;
  logic [14:0]                         temp_q, hum_q;
  logic signed [15:0]                  temp_s, hum_s;
  logic signed [14:0]                  temp_val;
  logic [13:0]                         hum_val;

  assign out_free = !result.valid || result.ready;
  assign s1_free  = !s1_valid || out_free;
  assign pop      = pop_valid && s1_free;

  // stage 1: scale products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_temp_prod <= hsfd_pkg::TEMP_PROD_W'(pop_data.temp_raw)
                    * hsfd_pkg::TEMP_PROD_W'(hsfd_pkg::TEMP_SCALE);
      s1_hum_prod  <= hsfd_pkg::HUM_PROD_W'(pop_data.humid_raw)
                    * hsfd_pkg::HUM_PROD_W'(hsfd_pkg::HUM_SCALE);
      s1_err       <= pop_data.crc_error;
    end
  end

  // stage 2: divide by full scale, offset, clamp humidity, zero on crc error
  always_comb begin
    temp_q = hsfd_pkg::div_full_scale(s1_temp_prod);
    hum_q  = hsfd_pkg::div_full_scale({1'b0, s1_hum_prod});
    temp_s = $signed({1'b0, temp_q}) - hsfd_pkg::TEMP_OFFSET;
    hum_s  = $signed({1'b0, hum_q}) - hsfd_pkg::HUM_OFFSET;
    temp_val = temp_s[14:0];
    if (hum_s < 16'sd0) begin
      hum_val = '0;
    end else if (hum_s > $signed({2'b00, hsfd_pkg::HUM_MAX})) begin
      hum_val = hsfd_pkg::HUM_MAX;
    end else begin
      hum_val = hum_s[13:0];
    end
    if (s1_err) begin
      temp_val = '0;
      hum_val  = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      result.temperature_centi <= temp_val;
      result.humidity_centi    <= hum_val;
      result.crc_error         <= s1_err;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.crc_error) |->
      (result.temperature_centi == 15'sd0 && result.humidity_centi == 14'd0))
    else $error("nonzero value on crc error");

  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.humidity_centi <= hsfd_pkg::HUM_MAX))
    else $error("humidity past clamp");

endmodule

FILE: rtl/humidity_sensor_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_unit
// Decodes six-byte temperature/humidity sensor frames with crc-8 checks
// into temperature and humidity in hundredths.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | words
//  rx      | in  | rx_byte[7:0], frame_start                        | one per byte
//  result  | out | temperature_centi[14:0] s, humidity_centi[13:0], | one per frame
//          |     | crc_error                                        |
//
// One byte is taken per cycle while the queue has room; the front updates
// position and crc in the cycle it takes the byte. A frame result follows
// its last byte through the queue, written on the accepting edge, then the
// multiply stage, then divide/offset/clamp into the result reg.
// Synchronous reset clears position, crc, queue and valid flags.
// A stalled result backs up the pipeline and queue; rx.ready drops only
// when the queue is full.
module humidity_sensor_frame_decoder_unit #(
  parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  hsfd_rx_if.sink    rx,
  hsfd_res_if.source result
);

  logic             push_valid, push_ready;
  hsfd_pkg::frame_t push_data;
  logic             pop_valid, pop;
  hsfd_pkg::frame_t pop_data;

  hsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  hsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  hsfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .result    (result)
  );

endmodule
